// ===== hw/rtl/lidar_point_pixel_projector_assert.svh =====
// assertion macros for the lidar point pixel projector
`ifndef LIDAR_POINT_PIXEL_PROJECTOR_ASSERT_SVH
`define LIDAR_POINT_PIXEL_PROJECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define LPP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpp assertion failed");
`define LPP_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lpp reset assertion failed");
`else
`define LPP_ASSERT(name, clk, rst_n, prop)
`define LPP_ASSERT_RST(name, clk, prop)
`endif

`endif

// ===== hw/rtl/lpp_pkg.sv =====
package lpp_pkg;

  localparam int COEF_W  = 27;
  localparam int TRANS_W = 36;
  localparam int PIX_W   = 16;
  localparam int TGT_W   = 11;
  localparam int CLASS_W = 8;
  localparam int CFG_DW  = 11;
  localparam int CFG_IW  = 3;
  localparam int COL_W   = 8;

  localparam logic [CFG_IW-1:0] REG_OBJ_U = 3'd0;
  localparam logic [CFG_IW-1:0] REG_OBJ_V = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LANE_U = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LANE_V = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CLASS = 3'd4;

  // camera times extrinsic matrix, signed q10.16, translation in mm
  localparam logic signed [COEF_W-1:0] COEF [3][3] = '{
    '{ 27'sd37339652, -27'sd45576028, -27'sd1473750 },
    '{ 27'sd24833042, -27'sd1002106,  -27'sd45064249 },
    '{ 27'sd65465,    -27'sd2218,     -27'sd2107 }
  };
  localparam logic signed [TRANS_W-1:0] TRANS [3] = '{
    -36'sd23247914487, -36'sd13699253299, -36'sd36395811
  };

  localparam int RANGE_MAX_MM = 100000;
  localparam int OBJ_MIN_MM   = 1200;
  localparam int LANE_MIN_MM  = 1500;
  localparam int MID_MM       = 10000;

  // floor(n / 10000) = (n * RECIP_K) >> RECIP_SH for n below 2^22
  localparam int RECIP_W = 22;
  localparam logic [RECIP_W-1:0] RECIP_K = 22'd3435974;
  localparam int RECIP_SH = 35;

  typedef struct packed {
    logic             lane;
    logic             last;
    logic             inr;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
  } side_t;

endpackage

// ===== hw/rtl/lidar_point_pixel_projector.sv =====
// channel | signals                                          | direction
// input   | in_valid_i in_ready_o point_* cloud_select_i ... | in
// output  | out_valid_o out_ready_i pixel_* ... last_result_o | out
// config  | cfg_we_i cfg_idx_i cfg_wdata_i                    | in
// one transaction per cycle unless the output stalls; after stages 1-4 the
// one-bit-per-stage divider serves both pixels before saturation and output
// reset clears the valid bits, the target registers and the latched rows
// each stage holds while the stage after it is full and stalled, so bubbles
// close up and a stalled output stops only the full part of the pipe
`include "lidar_point_pixel_projector_assert.svh"

module lidar_point_pixel_projector
  import lpp_pkg::*;
#(
  parameter int COORD_BITS   = 18,
  parameter int PIXEL_BITS   = 16,
  parameter int MATCH_RADIUS = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IW-1:0]            cfg_idx_i,
  input  logic [CFG_DW-1:0]            cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic                         cloud_select_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [PIX_W-1:0]      pixel_u_o,
  output logic signed [PIX_W-1:0]      pixel_v_o,
  output logic                         in_range_o,
  output logic [COL_W-1:0]             red_level_o,
  output logic [COL_W-1:0]             green_level_o,
  output logic                         target_hit_o,
  output logic                         distance_valid_o,
  output logic [PIX_W-1:0]             row_distance_o,
  output logic                         last_result_o
);

  localparam int PW = COORD_BITS + COEF_W;
  localparam int NW = COORD_BITS + 31;
  localparam int QB = PIXEL_BITS;
  localparam int DW = NW + QB;
  localparam int EW = PIX_W + 2;
  localparam int MW = 2 * RECIP_W;
  localparam logic [QB-1:0] LO_MAG = {1'b1, {(QB-1){1'b0}}};
  localparam logic [QB-1:0] HI_MAG = {1'b0, {(QB-1){1'b1}}};
  localparam logic signed [EW-1:0] RAD = EW'(MATCH_RADIUS);

  typedef struct packed {
    logic [NW-1:0] ru;
    logic [NW-1:0] rv;
    logic [NW-1:0] wm;
    logic [QB-1:0] qu;
    logic [QB-1:0] qv;
    logic          ovu;
    logic          ovv;
    logic          su;
    logic          sv;
    logic          zero;
    side_t         side;
  } div_t;

  function automatic logic [PIX_W-1:0] sat_pix(input logic [QB-1:0] q, input logic ov,
                                               input logic neg);
    logic signed [QB:0] v;
    if (neg) begin
      if (ov || q > LO_MAG) v = -$signed({1'b0, LO_MAG});
      else v = -$signed({1'b0, q});
    end else begin
      if (ov || q > HI_MAG) v = $signed({1'b0, HI_MAG});
      else v = $signed({1'b0, q});
    end
    return PIX_W'(v);
  endfunction

  function automatic logic near(input logic [PIX_W-1:0] p, input logic [TGT_W-1:0] t);
    logic signed [EW-1:0] df;
    df = $signed({{2{p[PIX_W-1]}}, p}) - $signed({{(EW-TGT_W){1'b0}}, t});
    return (df >= -RAD) && (df <= RAD);
  endfunction

  // configuration registers
  logic [TGT_W-1:0]   obj_u_q, obj_v_q, lane_u_q, lane_v_q;
  logic [CLASS_W-1:0] class_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_u_q  <= '0;
      obj_v_q  <= '0;
      lane_u_q <= '0;
      lane_v_q <= '0;
      class_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OBJ_U:  obj_u_q <= cfg_wdata_i[TGT_W-1:0];
        REG_OBJ_V:  obj_v_q <= cfg_wdata_i[TGT_W-1:0];
        REG_LANE_U: lane_u_q <= cfg_wdata_i[TGT_W-1:0];
        REG_LANE_V: lane_v_q <= cfg_wdata_i[TGT_W-1:0];
        REG_CLASS:  class_q <= cfg_wdata_i[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, sf_v_q, out_valid_q;
  logic [QB:0] dv_v_q;
  logic en_s1, en_s2, en_s3, en_s4, en_sf, en_out;
  logic [QB:0] en_dv;

  always_comb begin
    en_out    = !out_valid_q || out_ready_i;
    en_sf     = !sf_v_q || en_out;
    en_dv[QB] = !dv_v_q[QB] || en_sf;
    for (int j = QB - 1; j >= 0; j--) begin
      en_dv[j] = !dv_v_q[j] || en_dv[j+1];
    end
    en_s4 = !s4_v_q || en_dv[0];
    en_s3 = !s3_v_q || en_s4;
    en_s2 = !s2_v_q || en_s3;
    en_s1 = !s1_v_q || en_s2;
  end

  assign in_ready_o = en_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      dv_v_q      <= '0;
      sf_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_s1) s1_v_q <= in_valid_i;
      if (en_s2) s2_v_q <= s1_v_q;
      if (en_s3) s3_v_q <= s2_v_q;
      if (en_s4) s4_v_q <= s3_v_q;
      if (en_dv[0]) dv_v_q[0] <= s4_v_q;
      for (int j = 1; j <= QB; j++) begin
        if (en_dv[j]) dv_v_q[j] <= dv_v_q[j-1];
      end
      if (en_sf) sf_v_q <= dv_v_q[QB];
      if (en_out) out_valid_q <= sf_v_q;
    end
  end

  // stage 1: products, range filter, colour numerators
  logic signed [COORD_BITS-1:0] xyz [3];
  logic signed [31:0]           x_ext;
  logic signed [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]          dabs;
  logic [13:0]                  d14, dg14;
  logic                         inr_d;

  assign xyz[0] = point_x_i;
  assign xyz[1] = point_y_i;
  assign xyz[2] = point_z_i;
  assign x_ext  = 32'(point_x_i);
  assign inr_d  = (x_ext >= (cloud_select_i ? LANE_MIN_MM : OBJ_MIN_MM)) &&
                  (x_ext <= RANGE_MAX_MM);
  assign dx     = (COORD_BITS+1)'(point_x_i) - (COORD_BITS+1)'(MID_MM);
  assign dabs   = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
  assign d14    = dabs[13:0];
  assign dg14   = 14'(MID_MM) - d14;

  logic signed [PW-1:0] s1_prod_q [3][3];
  side_t                s1_side_q;
  logic                 s1_sat_q;
  logic [RECIP_W-1:0]   s1_nred_q, s1_ngrn_q;

  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod_q[r][c] <= PW'(xyz[c]) * PW'(COEF[r][c]);
        end
      end
      s1_side_q <= '{lane: cloud_select_i, last: last_point_i, inr: inr_d,
                     red: '0, green: '0};
      s1_sat_q  <= dabs >= (COORD_BITS+1)'(MID_MM);
      s1_nred_q <= RECIP_W'({d14, 8'h00}) - RECIP_W'(d14);
      s1_ngrn_q <= RECIP_W'({dg14, 8'h00}) - RECIP_W'(dg14);
    end
  end

  // stage 2: row sums, reciprocal products
  logic signed [NW-1:0] s2_a_q, s2_b_q, s2_w_q;
  side_t                s2_side_q;
  logic                 s2_sat_q;
  logic [MW-1:0]        s2_mred_q, s2_mgrn_q;

  always_ff @(posedge clk_i) begin
    if (en_s2) begin
      s2_a_q <= NW'(s1_prod_q[0][0]) + NW'(s1_prod_q[0][1]) + NW'(s1_prod_q[0][2]) +
                NW'(TRANS[0]);
      s2_b_q <= NW'(s1_prod_q[1][0]) + NW'(s1_prod_q[1][1]) + NW'(s1_prod_q[1][2]) +
                NW'(TRANS[1]);
      s2_w_q <= NW'(s1_prod_q[2][0]) + NW'(s1_prod_q[2][1]) + NW'(s1_prod_q[2][2]) +
                NW'(TRANS[2]);
      s2_side_q <= s1_side_q;
      s2_sat_q  <= s1_sat_q;
      s2_mred_q <= MW'(s1_nred_q) * MW'(RECIP_K);
      s2_mgrn_q <= MW'(s1_ngrn_q) * MW'(RECIP_K);
    end
  end

  // stage 3: u numerator with the column offset, final colours
  logic signed [NW-1:0] s3_nu_q, s3_b_q, s3_w_q;
  side_t                s3_side_q;

  always_ff @(posedge clk_i) begin
    if (en_s3) begin
      s3_nu_q <= s2_a_q + (s2_w_q <<< 4) + (s2_w_q <<< 2);
      s3_b_q  <= s2_b_q;
      s3_w_q  <= s2_w_q;
      s3_side_q <= s2_side_q;
      if (!s2_side_q.inr) begin
        s3_side_q.red   <= '0;
        s3_side_q.green <= '0;
      end else if (s2_sat_q) begin
        s3_side_q.red   <= '1;
        s3_side_q.green <= '0;
      end else begin
        s3_side_q.red   <= s2_mred_q[RECIP_SH+COL_W-1:RECIP_SH];
        s3_side_q.green <= s2_mgrn_q[RECIP_SH+COL_W-1:RECIP_SH];
      end
    end
  end

  // stage 4: magnitudes and quotient signs
  logic [NW-1:0] s4_nu_m_q, s4_b_m_q, s4_w_m_q;
  logic          s4_su_q, s4_sv_q, s4_zero_q;
  side_t         s4_side_q;

  always_ff @(posedge clk_i) begin
    if (en_s4) begin
      s4_nu_m_q <= s3_nu_q[NW-1] ? NW'(-s3_nu_q) : NW'(s3_nu_q);
      s4_b_m_q  <= s3_b_q[NW-1] ? NW'(-s3_b_q) : NW'(s3_b_q);
      s4_w_m_q  <= s3_w_q[NW-1] ? NW'(-s3_w_q) : NW'(s3_w_q);
      s4_su_q   <= s3_nu_q[NW-1] ^ s3_w_q[NW-1];
      s4_sv_q   <= s3_b_q[NW-1] ^ s3_w_q[NW-1];
      s4_zero_q <= s3_w_q == '0;
      s4_side_q <= s3_side_q;
    end
  end

  // divider: stage 0 flags quotients too large for the pixel width
  div_t dv_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_dv[0]) begin
      dv_q[0].ru   <= s4_nu_m_q;
      dv_q[0].rv   <= s4_b_m_q;
      dv_q[0].wm   <= s4_w_m_q;
      dv_q[0].qu   <= '0;
      dv_q[0].qv   <= '0;
      dv_q[0].ovu  <= DW'(s4_nu_m_q) >= {s4_w_m_q, {QB{1'b0}}};
      dv_q[0].ovv  <= DW'(s4_b_m_q) >= {s4_w_m_q, {QB{1'b0}}};
      dv_q[0].su   <= s4_su_q;
      dv_q[0].sv   <= s4_sv_q;
      dv_q[0].zero <= s4_zero_q;
      dv_q[0].side <= s4_side_q;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int B = QB - j;
    logic [DW-1:0] tgt, eu, ev;
    logic          geu, gev;
    div_t          nxt_d;

    assign tgt = DW'(dv_q[j-1].wm) << B;
    assign eu  = DW'(dv_q[j-1].ru);
    assign ev  = DW'(dv_q[j-1].rv);
    assign geu = eu >= tgt;
    assign gev = ev >= tgt;

    always_comb begin
      nxt_d = dv_q[j-1];
      if (geu) begin
        nxt_d.ru    = NW'(eu - tgt);
        nxt_d.qu[B] = 1'b1;
      end
      if (gev) begin
        nxt_d.rv    = NW'(ev - tgt);
        nxt_d.qv[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_dv[j]) dv_q[j] <= nxt_d;
    end
  end

  // sign and saturation
  logic [PIX_W-1:0] sf_pu_q, sf_pv_q;
  logic             sf_ok_q;
  side_t            sf_side_q;

  always_ff @(posedge clk_i) begin
    if (en_sf) begin
      sf_pu_q   <= sat_pix(dv_q[QB].qu, dv_q[QB].ovu, dv_q[QB].su);
      sf_pv_q   <= sat_pix(dv_q[QB].qv, dv_q[QB].ovv, dv_q[QB].sv);
      sf_ok_q   <= dv_q[QB].side.inr && !dv_q[QB].zero;
      sf_side_q <= dv_q[QB].side;
    end
  end

  // target match, latched rows, distance report
  logic [PIX_W-1:0] obj_hit_v_q, obj_hit_v_d, lane_hit_v_q, lane_hit_v_d;
  logic             hit_d, dvalid_d, out_load;
  logic signed [PIX_W:0] vdiff;

  assign out_load = en_out && sf_v_q;

  always_comb begin
    hit_d = sf_ok_q && (sf_side_q.lane ?
            (near(sf_pu_q, lane_u_q) && near(sf_pv_q, lane_v_q)) :
            (near(sf_pu_q, obj_u_q) && near(sf_pv_q, obj_v_q)));
    obj_hit_v_d  = (hit_d && !sf_side_q.lane) ? sf_pv_q : obj_hit_v_q;
    lane_hit_v_d = (hit_d && sf_side_q.lane) ? sf_pv_q : lane_hit_v_q;
    dvalid_d = sf_side_q.lane && sf_side_q.last && (obj_u_q != '0) && (obj_v_q != '0) &&
               (lane_u_q != '0) && (lane_v_q != '0) && (class_q != '0);
    vdiff = $signed({obj_hit_v_d[PIX_W-1], obj_hit_v_d}) -
            $signed({lane_hit_v_d[PIX_W-1], lane_hit_v_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_hit_v_q  <= '0;
      lane_hit_v_q <= '0;
    end else if (out_load) begin
      obj_hit_v_q  <= obj_hit_v_d;
      lane_hit_v_q <= lane_hit_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_u_o        <= sf_ok_q ? sf_pu_q : '0;
      pixel_v_o        <= sf_ok_q ? sf_pv_q : '0;
      in_range_o       <= sf_side_q.inr;
      red_level_o      <= sf_side_q.red;
      green_level_o    <= sf_side_q.green;
      target_hit_o     <= hit_d;
      distance_valid_o <= dvalid_d;
      row_distance_o   <= !dvalid_d ? '0 :
                          vdiff[PIX_W] ? PIX_W'(-vdiff) : PIX_W'(vdiff);
      last_result_o    <= sf_side_q.last;
    end
  end

  assign out_valid_o = out_valid_q;

  `LPP_ASSERT(a_dist_on_last, clk_i, rst_ni, out_valid_o && distance_valid_o |-> last_result_o)
  `LPP_ASSERT(a_out_of_range_blank, clk_i, rst_ni, out_valid_o && !in_range_o |-> !target_hit_o && red_level_o == '0 && green_level_o == '0)
  `LPP_ASSERT(a_stall_from_output, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i)
  `LPP_ASSERT(a_latch_on_load, clk_i, rst_ni, !$stable(obj_hit_v_q) || !$stable(lane_hit_v_q) |-> $past(out_load))
  `LPP_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o)

endmodule

// ===== test/lidar_point_pixel_projector_test.sv =====
`timescale 1ns / 1ps

module lidar_point_pixel_projector_test;
  import lpp_pkg::*;

  localparam int CB = 18;
  localparam int LATENCY_WAIT = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RADIUS = 5;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

  localparam longint M00 = 64'sd37339652, M01 = -64'sd45576028, M02 = -64'sd1473750;
  localparam longint M03 = -64'sd23247914487;
  localparam longint M10 = 64'sd24833042, M11 = -64'sd1002106, M12 = -64'sd45064249;
  localparam longint M13 = -64'sd13699253299;
  localparam longint M20 = 64'sd65465, M21 = -64'sd2218, M22 = -64'sd2107;
  localparam longint M23 = -64'sd36395811;

  typedef struct {
    logic signed [CB-1:0] x, y, z;
    logic lane, last;
  } point_t;

  typedef struct {
    logic signed [PIX_W-1:0] pu, pv;
    logic inr;
    logic [COL_W-1:0] red, green;
    logic hit, dvalid;
    logic [PIX_W-1:0] row_dist;
    logic last;
  } pixel_result_t;

  logic clk_i = 0, rst_ni = 1;
  logic cfg_we_i = 0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 0, in_ready_o;
  logic signed [CB-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic cloud_select_i = 0, last_point_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic signed [PIX_W-1:0] pixel_u_o, pixel_v_o;
  logic in_range_o, target_hit_o, distance_valid_o, last_result_o;
  logic [COL_W-1:0] red_level_o, green_level_o;
  logic [PIX_W-1:0] row_distance_o;

  lidar_point_pixel_projector DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  point_t point_queue[$];
  pixel_result_t expected_pixels[$];
  point_t cur_point;
  int errors = 0, send_gap = 0, stall_left = 0, idle_cycles = 0;
  bit hold = 1, calm = 0;
  int obj_tu = 0, obj_tv = 0, lane_tu = 0, lane_tv = 0, obj_class = 0;
  longint obj_hit_v = 0, lane_hit_v = 0;

  function automatic void add_point(point_t p);
    point_queue.insert(point_queue.size(), p);
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic bit project(point_t p, output longint pu, output longint pv);
    longint x = p.x, y = p.y, z = p.z;
    longint a = M00 * x + M01 * y + M02 * z + M03;
    longint b = M10 * x + M11 * y + M12 * z + M13;
    longint w = M20 * x + M21 * y + M22 * z + M23;
    pu = 0;
    pv = 0;
    if (w == 0) return 0;
    pu = sat16((a + 20 * w) / w);
    pv = sat16(b / w);
    return 1;
  endfunction

  function automatic bit near(longint p, int t);
    return p >= t - RADIUS && p <= t + RADIUS;
  endfunction

  function automatic pixel_result_t predict_projection(point_t p);
    pixel_result_t r;
    longint x = p.x, pu, pv, d, diff;
    bit ok;
    r = '{default: '0};
    r.last = p.last;
    r.inr = x >= (p.lane ? LANE_MIN_MM : OBJ_MIN_MM) && x <= RANGE_MAX_MM;
    if (r.inr) begin
      d = x - MID_MM;
      if (d < 0) d = -d;
      r.red = (255 * d / MID_MM > 255) ? 8'd255 : 8'(255 * d / MID_MM);
      r.green = (d >= MID_MM) ? 8'd0 : 8'(255 * (MID_MM - d) / MID_MM);
      ok = project(p, pu, pv);
      if (ok) begin
        r.pu = PIX_W'(pu);
        r.pv = PIX_W'(pv);
        if (p.lane) begin
          r.hit = near(pu, lane_tu) && near(pv, lane_tv);
          if (r.hit) lane_hit_v = pv;
        end else begin
          r.hit = near(pu, obj_tu) && near(pv, obj_tv);
          if (r.hit) obj_hit_v = pv;
        end
      end
    end
    if (p.lane && p.last && obj_tu != 0 && obj_tv != 0 && lane_tu != 0 && lane_tv != 0
        && obj_class != 0) begin
      diff = obj_hit_v - lane_hit_v;
      if (diff < 0) diff = -diff;
      r.dvalid = 1;
      r.row_dist = diff[15:0];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else begin : drive
      bit busy;
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_pixels.insert(expected_pixels.size(), predict_projection(cur_point));
        busy = 0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (point_queue.size() > 0 && !hold) begin
          cur_point = point_queue.pop_front();
          point_x_i <= cur_point.x;
          point_y_i <= cur_point.y;
          point_z_i <= cur_point.z;
          cloud_select_i <= cur_point.lane;
          last_point_i <= cur_point.last;
          busy = 1;
          send_gap = pick_gap();
        end
      end
      in_valid_i <= busy;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
    end else begin : check
      pixel_result_t e;
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction at %0t", $time);
        end else begin
          e = expected_pixels.pop_front();
          if (pixel_u_o !== e.pu || pixel_v_o !== e.pv || in_range_o !== e.inr ||
              red_level_o !== e.red || green_level_o !== e.green ||
              target_hit_o !== e.hit || distance_valid_o !== e.dvalid ||
              row_distance_o !== e.row_dist || last_result_o !== e.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: exp u=%0d v=%0d r=%b red=%0d grn=%0d",
                $time, e.pu, e.pv, e.inr, e.red, e.green,
                " hit=%b dv=%b dist=%0d last=%b", e.hit, e.dvalid, e.row_dist, e.last);
              $display("  got u=%0d v=%0d r=%b red=%0d grn=%0d hit=%b dv=%b dist=%0d last=%b",
                pixel_u_o, pixel_v_o, in_range_o, red_level_o, green_level_o,
                target_hit_o, distance_valid_o, row_distance_o, last_result_o);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
        if (!calm && $urandom_range(9) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drained();
    while (point_queue.size() > 0 || in_valid_i || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[CFG_DW-1:0];
    case (idx)
      REG_OBJ_U: obj_tu = val & 'h7ff;
      REG_OBJ_V: obj_tv = val & 'h7ff;
      REG_LANE_U: lane_tu = val & 'h7ff;
      REG_LANE_V: lane_tv = val & 'h7ff;
      REG_CLASS: obj_class = val & 'hff;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic point_t mk(longint x, longint y, longint z, bit lane, bit last);
    point_t p;
    p.x = CB'(x);
    p.y = CB'(y);
    p.z = CB'(z);
    p.lane = lane;
    p.last = last;
    return p;
  endfunction

  function automatic point_t rand_point();
    return mk($signed(18'($urandom)), $signed(18'($urandom)), $signed(18'($urandom)),
              1'($urandom_range(1)), $urandom_range(7) == 0);
  endfunction

  // point that projects inside the target register range, or random targets if none is found
  function automatic point_t find_anchor(bit lane, output int tu, output int tv);
    point_t p;
    longint pu, pv;
    for (int i = 0; i < 200; i++) begin
      p = mk($urandom_range(40000, 2000), int'($urandom_range(10000)) - 5000,
             int'($urandom_range(4000)) - 3000, lane, 0);
      if (project(p, pu, pv) && pu >= 1 && pu <= 2047 && pv >= 1 && pv <= 2047) begin
        tu = int'(pu);
        tv = int'(pv);
        return p;
      end
    end
    tu = $urandom_range(2047, 1);
    tv = $urandom_range(2047, 1);
    return p;
  endfunction

  function automatic void push_cloud(point_t anchor, int n, int spread);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p = anchor;
      p.x = CB'(anchor.x + $signed($urandom_range(2 * spread)) - spread);
      p.y = CB'(anchor.y + $signed($urandom_range(2 * spread)) - spread);
      p.z = CB'(anchor.z + $signed($urandom_range(2 * spread)) - spread);
      p.last = (i == n - 1);
      add_point($urandom_range(9) == 0 ? rand_point() : p);
    end
  endfunction

  initial begin : stimulus
    point_t oa, la;
    int otu, otv, ltu, ltv, z0;
    longint n;
    rst_ni <= 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: range edges, field extremes, zero depth
    add_point(mk(-131072, -131072, -131072, 0, 0));
    add_point(mk(131071, 131071, 131071, 1, 1));
    add_point(mk(1199, 0, 0, 0, 0));
    add_point(mk(1200, 0, 0, 0, 0));
    add_point(mk(1499, 0, 0, 1, 0));
    add_point(mk(1500, 0, 0, 1, 0));
    add_point(mk(100000, 131071, -131072, 0, 0));
    add_point(mk(100001, 0, 0, 1, 0));
    add_point(mk(10000, 0, 0, 0, 0));
    add_point(mk(20000, -131072, 131071, 1, 0));
    add_point(mk(1200, 131071, 131071, 0, 1));
    add_point(mk(1500, -131072, -131072, 1, 1));
    add_point(mk(0, 0, 0, 1, 1));
    n = 1200 * M20 + M23;
    z0 = 0;
    while ((n + M22 * z0) % M21 != 0) z0++;
    add_point(mk(1200, -(n + M22 * z0) / M21, z0, 0, 0));
    add_point(mk(1200, -(n + M22 * z0) / M21, z0, 1, 1));
    hold = 0;
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      hold = 1;
      calm = (ph % 4 == 3);
      oa = find_anchor(0, otu, otv);
      la = find_anchor(1, ltu, ltv);
      case (ph)
        0: begin otu = 2047; otv = 2047; ltu = 2047; ltv = 2047; end
        1: begin otu = 0; end
        default: ;
      endcase
      write_reg(REG_OBJ_U, otu);
      write_reg(REG_OBJ_V, otv);
      write_reg(REG_LANE_U, ltu);
      write_reg(REG_LANE_V, ltv);
      write_reg(REG_CLASS, ph == 2 ? 0 : ph == 3 ? 255 : $urandom_range(255, 1));
      if (ph == 4) write_reg(REG_UNUSED, $urandom);
      for (int c = 0; c < 4; c++) begin
        push_cloud(oa, $urandom_range(20, 3), $urandom_range(3) == 0 ? 2000 : 60);
        push_cloud(la, $urandom_range(20, 3), $urandom_range(3) == 0 ? 2000 : 60);
        repeat ($urandom_range(3)) add_point(rand_point());
      end
      hold = 0;
      wait_drained();
    end

    if (errors == 0 && expected_pixels.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
